// File: src/tft_pkg.sv
// tft_pkg: shared constants, result codes and the request token carried
// along the flow table cell chain. No dependencies.

package tft_pkg;

  localparam int DEFAULT_TABLE_ENTRIES = 64;

  // smallest legal IP or TCP header, in bytes
  localparam logic [6:0] MIN_HDR_BYTES = 7'd20;

  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_SYN = 8'h02;

  // result kinds
  localparam logic [1:0] RES_CLOSED     = 2'd0;
  localparam logic [1:0] RES_BAD_HDR    = 2'd1;
  localparam logic [1:0] RES_TABLE_FULL = 2'd2;

  // closed flow record as it leaves the table
  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] bytes_up;
    logic [31:0] bytes_down;
    logic [31:0] duration_seconds;
  } flow_rec_t;

  // one request as it walks the cell chain
  typedef struct packed {
    logic        bad;       // header length check failed
    logic        syn;       // flags are exactly SYN
    logic        fin;       // FIN bit set and not a bare SYN
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] now_seconds;
    logic [15:0] add_bytes; // 20 plus any positive payload
    logic        opened;    // a free slot was taken by this SYN
    logic        matched;   // a slot has already handled this request
    logic        closed;    // second FIN seen, record is valid
    flow_rec_t   rec;
  } token_t;

endpackage

// File: src/tft_if.sv
// tft_hdr_if and tft_rec_if: valid/ready channels for parsed headers and
// flow table results. Depends on nothing.

interface tft_hdr_if;
  logic        valid;
  logic        ready;
  logic [3:0]  ip_header_words;
  logic [3:0]  tcp_header_words;
  logic [7:0]  tcp_flag_bits;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [15:0] ip_total_length;
  logic [31:0] now_seconds;

  modport source (
    output valid, ip_header_words, tcp_header_words, tcp_flag_bits,
           source_address, dest_address, source_port, dest_port,
           ip_total_length, now_seconds,
    input  ready
  );
  modport sink (
    input  valid, ip_header_words, tcp_header_words, tcp_flag_bits,
           source_address, dest_address, source_port, dest_port,
           ip_total_length, now_seconds,
    output ready
  );
endinterface

interface tft_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] flow_source_address;
  logic [31:0] flow_dest_address;
  logic [15:0] flow_source_port;
  logic [15:0] flow_dest_port;
  logic [31:0] bytes_up;
  logic [31:0] bytes_down;
  logic [31:0] duration_seconds;

  modport source (
    output valid, result_kind, flow_source_address, flow_dest_address,
           flow_source_port, flow_dest_port, bytes_up, bytes_down,
           duration_seconds,
    input  ready
  );
  modport sink (
    input  valid, result_kind, flow_source_address, flow_dest_address,
           flow_source_port, flow_dest_port, bytes_up, bytes_down,
           duration_seconds,
    output ready
  );
endinterface

// File: src/tft_decode.sv
// tft_decode: turns one parsed header into the request token that enters
// the cell chain. Depends on tft_pkg.

module tft_decode (
  input  logic [3:0]      ip_header_words,
  input  logic [3:0]      tcp_header_words,
  input  logic [7:0]      tcp_flag_bits,
  input  logic [31:0]     source_address,
  input  logic [31:0]     dest_address,
  input  logic [15:0]     source_port,
  input  logic [15:0]     dest_port,
  input  logic [15:0]     ip_total_length,
  input  logic [31:0]     now_seconds,
  output tft_pkg::token_t tok
);

  logic [5:0]  ip_bytes;
  logic [5:0]  tcp_bytes;
  logic [6:0]  hdr_bytes;
  logic [15:0] payload;

  // header sizes in bytes
  assign ip_bytes  = {ip_header_words, 2'b00};
  assign tcp_bytes = {tcp_header_words, 2'b00};
  assign hdr_bytes = {1'b0, ip_bytes} + {1'b0, tcp_bytes};
  assign payload   = ip_total_length - {9'd0, hdr_bytes};

  always_comb begin
    tok                = '0;
    tok.bad            = ({1'b0, ip_bytes} < tft_pkg::MIN_HDR_BYTES) ||
                         ({1'b0, tcp_bytes} < tft_pkg::MIN_HDR_BYTES);
    tok.syn            = (tcp_flag_bits == tft_pkg::FLAG_SYN);
    tok.fin            = (tcp_flag_bits != tft_pkg::FLAG_SYN) &&
                         ((tcp_flag_bits & tft_pkg::FLAG_FIN) != 8'd0);
    tok.source_address = source_address;
    tok.dest_address   = dest_address;
    tok.source_port    = source_port;
    tok.dest_port      = dest_port;
    tok.now_seconds    = now_seconds;
    // payload only counts when positive
    if (ip_total_length > {9'd0, hdr_bytes}) begin
      tok.add_bytes = payload + {9'd0, tft_pkg::MIN_HDR_BYTES};
    end else begin
      tok.add_bytes = {9'd0, tft_pkg::MIN_HDR_BYTES};
    end
  end

endmodule

// File: src/tft_cell.sv
// tft_cell: one flow table slot plus one stage of the request chain. The
// request is checked against this slot and handed to the next cell.
// Depends on tft_pkg.

module tft_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            tok_in_valid,
  input  tft_pkg::token_t tok_in,
  output logic            tok_out_valid,
  output tft_pkg::token_t tok_out
);

  // slot state
  logic        slot_valid;
  logic [31:0] slot_source_address;
  logic [31:0] slot_dest_address;
  logic [15:0] slot_source_port;
  logic [15:0] slot_dest_port;
  logic [31:0] slot_bytes_up;
  logic [31:0] slot_bytes_down;
  logic [31:0] slot_start_time;
  logic        slot_fin_count;

  logic            active;
  logic            hit_fwd;
  logic            hit_rev;
  logic            open_here;
  logic            take;
  logic            closing;
  logic [16:0]     inc;
  logic [31:0]     bytes_up_next;
  logic [31:0]     bytes_down_next;
  tft_pkg::token_t tok_next;

  // tuple compare in both directions
  assign active  = tok_in_valid && !tok_in.bad;
  assign hit_fwd = slot_valid &&
                   (slot_source_address == tok_in.source_address) &&
                   (slot_dest_address == tok_in.dest_address) &&
                   (slot_source_port == tok_in.source_port) &&
                   (slot_dest_port == tok_in.dest_port);
  assign hit_rev = slot_valid &&
                   (slot_source_address == tok_in.dest_address) &&
                   (slot_dest_address == tok_in.source_address) &&
                   (slot_source_port == tok_in.dest_port) &&
                   (slot_dest_port == tok_in.source_port);

  // a SYN takes the lowest free slot; matching follows in slot order
  assign open_here = active && tok_in.syn && !tok_in.opened && !slot_valid;
  assign take      = active && !tok_in.matched && (hit_fwd || hit_rev || open_here);
  assign closing   = take && tok_in.fin && slot_fin_count && !open_here;

  // byte increment: a second FIN adds only its header
  always_comb begin
    if (tok_in.fin && slot_fin_count) begin
      inc = {10'd0, tft_pkg::MIN_HDR_BYTES};
    end else if (tok_in.fin) begin
      inc = {1'b0, tok_in.add_bytes} + {10'd0, tft_pkg::MIN_HDR_BYTES};
    end else begin
      inc = {1'b0, tok_in.add_bytes};
    end
  end

  // counter updates, forward hits the up direction
  always_comb begin
    bytes_up_next   = open_here ? 32'd0 : slot_bytes_up;
    bytes_down_next = open_here ? 32'd0 : slot_bytes_down;
    if (take && (hit_fwd || open_here)) begin
      bytes_up_next = bytes_up_next + {15'd0, inc};
    end else if (take) begin
      bytes_down_next = bytes_down_next + {15'd0, inc};
    end
  end

  // outgoing request
  always_comb begin
    tok_next = tok_in;
    if (open_here) begin
      tok_next.opened = 1'b1;
    end
    if (take) begin
      tok_next.matched = 1'b1;
    end
    if (closing) begin
      tok_next.closed               = 1'b1;
      tok_next.rec.source_address   = slot_source_address;
      tok_next.rec.dest_address     = slot_dest_address;
      tok_next.rec.source_port      = slot_source_port;
      tok_next.rec.dest_port        = slot_dest_port;
      tok_next.rec.bytes_up         = bytes_up_next;
      tok_next.rec.bytes_down       = bytes_down_next;
      tok_next.rec.duration_seconds = tok_in.now_seconds - slot_start_time;
    end
  end

  // slot valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (adv && open_here) begin
      slot_valid <= 1'b1;
    end else if (adv && closing) begin
      slot_valid <= 1'b0;
    end
  end

  // slot contents, the FIN mark survives non-FIN traffic
  always_ff @(posedge clk) begin
    if (adv && open_here) begin
      slot_source_address <= tok_in.source_address;
      slot_dest_address   <= tok_in.dest_address;
      slot_source_port    <= tok_in.source_port;
      slot_dest_port      <= tok_in.dest_port;
      slot_start_time     <= tok_in.now_seconds;
    end
    if (adv && (take || open_here)) begin
      slot_bytes_up   <= bytes_up_next;
      slot_bytes_down <= bytes_down_next;
      slot_fin_count  <= !open_here && (slot_fin_count || tok_in.fin);
    end
  end

  // hand the request to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
    end else if (adv) begin
      tok_out_valid <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_out <= tok_next;
    end
  end

  // a slot is never opened and closed by the same request
  a_open_close_excl: assert property (@(posedge clk) disable iff (rst)
    !(open_here && closing))
    else $error("slot opened and closed by one request");

  // a request that opens this slot and was not matched earlier is taken here
  a_open_takes: assert property (@(posedge clk) disable iff (rst)
    (open_here && !tok_in.matched) |-> take)
    else $error("opened slot not taken");

  // a closed slot is free on the next cycle
  a_close_frees: assert property (@(posedge clk) disable iff (rst)
    (adv && closing) |=> !slot_valid)
    else $error("closed slot still valid");

endmodule

// File: src/tcp_flow_tracker.sv
// tcp_flow_tracker: top level, decoder, cell chain and result register.
// Depends on tft_pkg, tft_if, tft_decode and tft_cell.

// The tracker accepts one parsed TCP/IP header per clock cycle and keeps up
// to TABLE_ENTRIES open flows. Each slot lives in its own cell, and every
// header walks the row of cells one cell per cycle, so a result (closed
// flow record, bad header or table full) reaches the output register in
// the order in which the headers were taken; headers that produce no
// result vanish at the end of the row. Throughput is one header per cycle.
// The whole row stalls only while a result reaches the end of the row and
// the previous one still waits in the output register. There is no
// clearing pass: reset empties the table at once.

module tcp_flow_tracker #(
  parameter int TABLE_ENTRIES = tft_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic       clk,
  input  logic       rst,
  tft_hdr_if.sink    hdr,
  tft_rec_if.source  rec
);

  tft_pkg::token_t tok   [TABLE_ENTRIES+1];
  logic            tok_v [TABLE_ENTRIES+1];
  logic            adv;
  logic            tail_res;
  logic [1:0]      tail_kind;
  tft_pkg::token_t tail;
  logic            rec_valid;
  logic [1:0]      rec_kind;
  tft_pkg::flow_rec_t rec_data;

  // header into request token
  tft_decode u_decode (
    .ip_header_words  (hdr.ip_header_words),
    .tcp_header_words (hdr.tcp_header_words),
    .tcp_flag_bits    (hdr.tcp_flag_bits),
    .source_address   (hdr.source_address),
    .dest_address     (hdr.dest_address),
    .source_port      (hdr.source_port),
    .dest_port        (hdr.dest_port),
    .ip_total_length  (hdr.ip_total_length),
    .now_seconds      (hdr.now_seconds),
    .tok              (tok[0])
  );

  assign tok_v[0]  = hdr.valid;
  assign hdr.ready = adv;

  // row of slot cells
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    tft_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .adv           (adv),
      .tok_in_valid  (tok_v[i]),
      .tok_in        (tok[i]),
      .tok_out_valid (tok_v[i+1]),
      .tok_out       (tok[i+1])
    );
  end

  // classify the request leaving the row
  assign tail     = tok[TABLE_ENTRIES];
  assign tail_res = tok_v[TABLE_ENTRIES] &&
                    (tail.bad || tail.closed || (tail.syn && !tail.opened));

  always_comb begin
    priority if (tail.bad) begin
      tail_kind = tft_pkg::RES_BAD_HDR;
    end else if (tail.closed) begin
      tail_kind = tft_pkg::RES_CLOSED;
    end else begin
      tail_kind = tft_pkg::RES_TABLE_FULL;
    end
  end

  // stall only when a result has nowhere to go
  assign adv = !(tail_res && rec_valid && !rec.ready);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (adv && tail_res) begin
      rec_valid <= 1'b1;
    end else if (rec.ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail_res) begin
      rec_kind <= tail_kind;
      if (tail.closed && !tail.bad) begin
        rec_data <= tail.rec;
      end else begin
        rec_data <= '0;
      end
    end
  end

  assign rec.valid               = rec_valid;
  assign rec.result_kind         = rec_kind;
  assign rec.flow_source_address = rec_data.source_address;
  assign rec.flow_dest_address   = rec_data.dest_address;
  assign rec.flow_source_port    = rec_data.source_port;
  assign rec.flow_dest_port      = rec_data.dest_port;
  assign rec.bytes_up            = rec_data.bytes_up;
  assign rec.bytes_down          = rec_data.bytes_down;
  assign rec.duration_seconds    = rec_data.duration_seconds;

  // a request that closes a flow is never also a SYN or a bad header
  a_close_kind: assert property (@(posedge clk) disable iff (rst)
    (tok_v[TABLE_ENTRIES] && tail.closed) |-> (!tail.bad && !tail.syn))
    else $error("closed record on a SYN or bad header");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (tail_res && rec_valid && !rec.ready) |-> !hdr.ready)
    else $error("row advanced over a blocked result");

  // only closed records carry flow fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && (rec_kind != tft_pkg::RES_CLOSED)) |->
      (rec_data.bytes_up == 32'd0 && rec_data.bytes_down == 32'd0 &&
       rec_data.duration_seconds == 32'd0))
    else $error("error result with nonzero fields");

  // result kind is always a defined code
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> (rec_kind == tft_pkg::RES_CLOSED ||
                   rec_kind == tft_pkg::RES_BAD_HDR ||
                   rec_kind == tft_pkg::RES_TABLE_FULL))
    else $error("undefined result kind");

endmodule
